### rtl/sfcd_pkg.sv
// Shared types, constants and the CRC byte update for the sensor frame decoder.
`default_nettype none

package sfcd_pkg;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int TEMP_F_W   = 17;
  localparam int MAG_W      = 15;
  localparam int POS_W      = 3;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_FUNC_CODE = 1'b0;  // word index of the function code register

  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [POS_W-1:0]    pos_t;

  // Result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_CODE_FAIL = 2'd1;
  localparam status_t ST_CRC_FAIL  = 2'd2;

  // Frame byte positions
  localparam pos_t POS_FUNC    = 3'd0;
  localparam pos_t POS_HUM_HI  = 3'd2;
  localparam pos_t POS_HUM_LO  = 3'd3;
  localparam pos_t POS_TEMP_HI = 3'd4;
  localparam pos_t POS_TEMP_LO = 3'd5;
  localparam pos_t POS_CRC_LO  = 3'd6;
  localparam pos_t POS_CRC_HI  = 3'd7;

  localparam word_t CRC_INIT        = 16'hFFFF;
  localparam word_t CRC_POLY        = 16'hA001;
  localparam byte_t FUNC_CODE_RESET = 8'h03;

  // Fahrenheit scaling: q = (9*|C| + 2) / 5 by reciprocal multiply.
  // 9*32767 + 2 fits in 19 bits; ceil(2^21 / 5) is exact over that range.
  localparam int SCALED_W   = 19;
  localparam int RECIP_SH   = 21;
  localparam int PROD_W     = 2 * SCALED_W;
  localparam logic [SCALED_W-1:0] RECIP_5 = 19'd419431;
  localparam logic [TEMP_F_W-1:0] F_OFFSET = 17'd320;

  // One byte of CRC-16/Modbus, bit-reflected, eight shift steps
  function automatic word_t crc_byte(input word_t crc_in, input byte_t data);
    word_t c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/sfcd_if.sv
// Valid/ready channel interfaces for frame bytes in and decoded results out.
`default_nettype none

interface sfcd_in_if;
  import sfcd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  frame_start;
  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface sfcd_out_if;
  import sfcd_pkg::*;
  logic                       valid;
  logic                       ready;
  status_t                    status;
  word_t                      humidity_tenths;
  logic signed [WORD_W-1:0]   temp_c_tenths;
  logic signed [TEMP_F_W-1:0] temp_f_tenths;
  modport source (output valid, output status, output humidity_tenths,
                  output temp_c_tenths, output temp_f_tenths, input ready);
  modport sink   (input valid, input status, input humidity_tenths,
                  input temp_c_tenths, input temp_f_tenths, output ready);
endinterface

`default_nettype wire

### rtl/sensor_frame_check_decode.sv
// Sensor response frame checker and decoder: CRC-16/Modbus check, unit conversion.
//
// Takes the 8-byte sensor response one byte per input word and returns one result
// word per frame, after byte 7. Byte 0 is checked against the function code register
// (APB byte address 0, reset 0x03); a CRC-16/Modbus (init 0xFFFF, reflected poly
// 0xA001) over bytes 0..5 is checked against bytes 6..7 (low byte first). Status 0 is
// ok, 1 function code mismatch (wins over a CRC fault), 2 CRC mismatch; on any fault
// the data fields are zero. Humidity comes out in tenths of a percent, temperature in
// two's complement tenths of a degree C and in tenths of a degree F rounded to
// nearest. frame_start on a byte restarts the frame with that byte as byte 0.
// Rate: one byte accepted every cycle, sustained; byte 7 loads the scaling stage,
// which passes it on to the output register. The cycle is set by the eight-step CRC
// byte update in front of the CRC register and, one stage later, by the 19x19
// reciprocal multiply that scales to Fahrenheit. Back-pressure on the result channel
// stalls the input only once both the scaling stage and the output register are full.
`default_nettype none

module sensor_frame_check_decode (
  input  logic                             clk,
  input  logic                             rst_n,
  sfcd_in_if.sink                          in_ch,
  sfcd_out_if.source                       out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sfcd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sfcd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sfcd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import sfcd_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  byte_t func_code_r, func_code_nxt;
  logic  cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[CFG_ADDR_W-1] == REG_FUNC_CODE);
  assign prdata  = cfg_hit ? {{(CFG_DATA_W-BYTE_W){1'b0}}, func_code_r} : '0;

  always_comb begin
    func_code_nxt = func_code_r;
    if (psel && penable && pwrite && pready && cfg_hit) begin
      func_code_nxt = pwdata[BYTE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: two stages (scaling, output). Every byte, final or not, is accepted
  // only while the scaling stage is empty or can drain into the output stage.
  // ---------------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, s1_free, in_fire, s1_load, out_load;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_free     = !s1_valid_r || out_free;
  assign in_ch.ready = s1_free;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = out_free && s1_valid_r;

  // ---------------------------------------------------------------------------
  // Frame state: position, running CRC, captured fields
  // ---------------------------------------------------------------------------
  pos_t  byte_pos_r, byte_pos_nxt;
  word_t crc_r, crc_nxt;
  logic  code_mis_r, code_mis_nxt;
  word_t hum_raw_r, hum_raw_nxt;
  word_t temp_raw_r, temp_raw_nxt;
  byte_t crc_lo_r, crc_lo_nxt;

  pos_t  pos;
  byte_t din;
  word_t crc_base;

  assign din      = in_ch.data_byte;
  // frame_start forces byte 0 whatever the counter says
  assign pos      = in_ch.frame_start ? POS_FUNC : byte_pos_r;
  assign crc_base = (pos == POS_FUNC) ? CRC_INIT : crc_r;
  assign s1_load  = in_fire && (pos == POS_CRC_HI);

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    crc_nxt      = crc_r;
    code_mis_nxt = code_mis_r;
    hum_raw_nxt  = hum_raw_r;
    temp_raw_nxt = temp_raw_r;
    crc_lo_nxt   = crc_lo_r;
    if (in_fire) begin
      // position wraps from 7 back to 0 by counter overflow
      byte_pos_nxt = pos + 3'd1;
      if (pos <= POS_TEMP_LO) begin
        crc_nxt = crc_byte(crc_base, din);
      end
      case (pos)
        POS_FUNC:    code_mis_nxt = (din != func_code_r);
        POS_HUM_HI:  hum_raw_nxt  = {din, hum_raw_r[BYTE_W-1:0]};
        POS_HUM_LO:  hum_raw_nxt  = {hum_raw_r[WORD_W-1:BYTE_W], din};
        POS_TEMP_HI: temp_raw_nxt = {din, temp_raw_r[BYTE_W-1:0]};
        POS_TEMP_LO: temp_raw_nxt = {temp_raw_r[WORD_W-1:BYTE_W], din};
        POS_CRC_LO:  crc_lo_nxt   = din;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Scaling stage: latch the verdict and the pre-scaled temperature at byte 7
  // ---------------------------------------------------------------------------
  status_t                s1_status_r, s1_status_nxt;
  word_t                  s1_hum_r;
  logic                   s1_neg_r;
  logic [MAG_W-1:0]       s1_mag_r;
  logic [SCALED_W-1:0]    s1_scaled_r, s1_scaled_nxt;
  logic [SCALED_W-1:0]    mag_ext;

  assign mag_ext = {{(SCALED_W-MAG_W){1'b0}}, temp_raw_r[MAG_W-1:0]};

  always_comb begin
    // function code fault takes priority over a CRC fault
    if (code_mis_r) begin
      s1_status_nxt = ST_CODE_FAIL;
    end else if ({din, crc_lo_r} != crc_r) begin
      s1_status_nxt = ST_CRC_FAIL;
    end else begin
      s1_status_nxt = ST_OK;
    end
    // 9*|C| + 2: the +2 turns the floor of the divide into round-to-nearest
    s1_scaled_nxt = (mag_ext << 3) + mag_ext + SCALED_W'(2);
  end

  assign s1_valid_nxt = s1_free ? s1_load : 1'b1;

  // ---------------------------------------------------------------------------
  // Output stage: divide by five, apply sign and offset, zero on fault
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0]          prod;
  logic [TEMP_F_W-1:0]        quot;
  logic [TEMP_F_W-1:0]        f_val;
  logic [WORD_W-1:0]          c_val;
  logic                       res_ok;

  status_t                    o_status_r;
  word_t                      o_hum_r, o_hum_nxt;
  logic signed [WORD_W-1:0]   o_tc_r, o_tc_nxt;
  logic signed [TEMP_F_W-1:0] o_tf_r, o_tf_nxt;

  assign prod   = PROD_W'(s1_scaled_r) * PROD_W'(RECIP_5);
  assign quot   = prod[RECIP_SH +: TEMP_F_W];
  assign res_ok = (s1_status_r == ST_OK);

  always_comb begin
    c_val = {1'b0, s1_mag_r};
    f_val = quot;
    if (s1_neg_r) begin
      // negative zero collapses to zero here as -0 == 0
      c_val = -{1'b0, s1_mag_r};
      f_val = -quot;
    end
    f_val     = f_val + F_OFFSET;
    o_hum_nxt = res_ok ? s1_hum_r : '0;
    o_tc_nxt  = res_ok ? $signed(c_val) : '0;
    o_tf_nxt  = res_ok ? $signed(f_val) : '0;
  end

  assign out_valid_nxt = out_free ? s1_valid_r : 1'b1;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = o_status_r;
  assign out_ch.humidity_tenths = o_hum_r;
  assign out_ch.temp_c_tenths   = o_tc_r;
  assign out_ch.temp_f_tenths   = o_tf_r;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_code_r <= FUNC_CODE_RESET;
      byte_pos_r  <= POS_FUNC;
      crc_r       <= CRC_INIT;
      code_mis_r  <= 1'b0;
      hum_raw_r   <= '0;
      temp_raw_r  <= '0;
      crc_lo_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      func_code_r <= func_code_nxt;
      byte_pos_r  <= byte_pos_nxt;
      crc_r       <= crc_nxt;
      code_mis_r  <= code_mis_nxt;
      hum_raw_r   <= hum_raw_nxt;
      temp_raw_r  <= temp_raw_nxt;
      crc_lo_r    <= crc_lo_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: load on stage advance, hold otherwise
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_status_r <= s1_status_nxt;
      s1_hum_r    <= hum_raw_r;
      s1_neg_r    <= temp_raw_r[WORD_W-1];
      s1_mag_r    <= temp_raw_r[MAG_W-1:0];
      s1_scaled_r <= s1_scaled_nxt;
    end
    if (out_load) begin
      o_status_r <= s1_status_r;
      o_hum_r    <= o_hum_nxt;
      o_tc_r     <= o_tc_nxt;
      o_tf_r     <= o_tf_nxt;
    end
  end

endmodule

`default_nettype wire
